FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, status codes and cell control struct.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 16;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_DEQUEUED = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic enq;      // accepted enqueue that fits
		logic deq;      // accepted dequeue on a non-empty queue
		logic occ;      // cell holds a live entry
		logic at_tail;  // cell is the first free slot
		logic left_gt;  // left neighbor yields to the new word
	} cell_ctl_t;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts, inserts or takes from its neighbor.
module spq_cell import spq_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] new_data,
	input  logic signed [PRIO_W-1:0] new_prio,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [PRIO_W-1:0] left_prio,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic signed [PRIO_W-1:0] right_prio,
	output logic signed [DATA_W-1:0] data_q,
	output logic signed [PRIO_W-1:0] prio_q,
	output logic                     gt
);

	// new word outranks this entry
	assign gt = ctl.occ && (new_prio > prio_q);

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (ctl.left_gt) begin
				data_q <= left_data;
				prio_q <= left_prio;
			end else if (gt || ctl.at_tail) begin
				data_q <= new_data;
				prio_q <= new_prio;
			end
		end else if (ctl.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue top level: chain of slot cells, entry count and output register.
//
//  channel | valid     | stall     | words
//  --------+-----------+-----------+------------------------------------------
//  in      | in_valid  | in_stall  | kind, item_data, item_priority
//  out     | out_valid | out_stall | status, out_data, out_priority, occupancy
//
// One word per cycle while in_stall is low: every cell compares and shifts in the same cycle.
// A result appears in the output register the cycle after its word is accepted.
// in_stall rises only while a result waits with out_stall high.
// Reset empties the queue at once; slot contents stay undefined until written.
module sorted_priority_queue_unit import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] item_data,
	input  logic signed [PRIO_W-1:0] item_priority,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] out_data,
	output logic signed [PRIO_W-1:0] out_priority,
	output logic [OCC_W-1:0]         occupancy
);

	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic signed [PRIO_W-1:0] out_prio_q;
	logic [OCC_W-1:0]         occ_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     do_enq;
	logic                     do_deq;
	logic [CNT_W-1:0]         count_next;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic signed [PRIO_W-1:0] cell_prio [CAPACITY];
	logic                     cell_gt   [CAPACITY];
	cell_ctl_t                cell_ctl  [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign do_enq   = accept && (kind == KIND_ENQ) && !full;
	assign do_deq   = accept && (kind == KIND_DEQ) && !empty;

	always_comb begin
		count_next = count_q;
		if (do_enq) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_comb begin
			cell_ctl[i].enq     = do_enq;
			cell_ctl[i].deq     = do_deq;
			cell_ctl[i].occ     = (CNT_W'(i) < count_q);
			cell_ctl[i].at_tail = (CNT_W'(i) == count_q);
			cell_ctl[i].left_gt = (i > 0) ? cell_gt[(i > 0) ? i - 1 : 0] : 1'b0;
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.new_data   (item_data),
			.new_prio   (item_priority),
			.left_data  (cell_data[(i > 0) ? i - 1 : 0]),
			.left_prio  (cell_prio[(i > 0) ? i - 1 : 0]),
			.right_data (cell_data[(i < CAPACITY - 1) ? i + 1 : i]),
			.right_prio (cell_prio[(i < CAPACITY - 1) ? i + 1 : i]),
			.data_q     (cell_data[i]),
			.prio_q     (cell_prio[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= do_deq ? cell_data[0] : '0;
			out_prio_q <= do_deq ? cell_prio[0] : '0;
			occ_q      <= OCC_W'(count_next);
			if (kind == KIND_ENQ) begin
				status_q <= full ? ST_FULL : ST_ENQUEUED;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_DEQUEUED;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign occupancy    = occ_q;

endmodule

FILE: rtl/spq_checker.sv
// Port checker for the sorted priority queue, bound to the top level.
module spq_port_checker import spq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] out_data,
	input logic signed [PRIO_W-1:0] out_priority,
	input logic [OCC_W-1:0]         occupancy
);

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(occupancy)))
		else $error("stalled result changed");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |->
		(out_data == '0 && out_priority == '0 && occupancy == '0))
		else $error("empty status with nonzero fields");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |->
		(occupancy == OCC_W'(CAPACITY) && out_data == '0 && out_priority == '0))
		else $error("full status with wrong fields");

	a_enq_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ENQUEUED) |->
		(out_data == '0 && out_priority == '0))
		else $error("enqueue status with nonzero payload");

endmodule

bind sorted_priority_queue_unit spq_port_checker u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_data     (out_data),
	.out_priority (out_priority),
	.occupancy    (occupancy)
);
